/* src/mmn_pkg.sv */
// Shared types and constants for the min/max unorm16 normalizer.
package mmn_pkg;

    localparam int QUOT_BITS = 16;
    localparam logic [QUOT_BITS-1:0] UNORM_MAX = '1;

    typedef enum logic [1:0] {
        MODE_RESTART = 2'd0,
        MODE_SCAN    = 2'd1,
        MODE_CONVERT = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 done;
        logic                 round_up;
        logic [QUOT_BITS-1:0] quot;
    } t_div_res;

endpackage

/* src/mmn_div.sv */
// Restoring radix-2 divider: one quotient bit per cycle, remainder-based rounding.
module mmn_div #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIDTH-1:0]     i_rem_init,
    input  logic [15:0]          i_low,
    input  logic [WIDTH-1:0]     i_den,
    output mmn_pkg::t_div_res    o_res
);
    import mmn_pkg::*;

    localparam int CNT_W = $clog2(QUOT_BITS);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WIDTH-1:0]     r_rem, n_rem;
    logic [QUOT_BITS-1:0] r_low, n_low;
    logic [QUOT_BITS-1:0] r_quot, n_quot;

    logic [WIDTH:0] w_trial;
    logic [WIDTH:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_low[QUOT_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign w_diff  = w_trial - {1'b0, i_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(QUOT_BITS - 1);
            n_rem  = i_rem_init;
            n_low  = i_low;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
            n_quot = {r_quot[QUOT_BITS-2:0], w_ge};
            n_low  = {r_low[QUOT_BITS-2:0], 1'b0};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
    end

    // round half up: twice the remainder at or above the divisor
    assign o_res.done     = r_done;
    assign o_res.round_up = {r_rem, 1'b0} >= {1'b0, i_den};
    assign o_res.quot     = r_quot;

endmodule

/* src/minmax_normalize_unorm16.sv */
// Top level: min/max scan and unorm16 conversion with a single divider.
//
// Input stream (s side): tuser carries the mode, tdata the signed Q16.16
// sample. Mode restart loads min and max with the sample, scan widens them,
// convert returns one item, the unused mode is dropped. Restart, scan and
// unused modes return nothing and leave the block ready for the next item.
// Output stream (m side): tdata carries the 16-bit normalized value,
// tuser[0] is set when max equals min (the value is then 0).
// A convert item passes through setup, prep, div and done: setup forms the
// range and the offset, prep starts the divider on the scaled dividend, the
// radix-2 divider develops the quotient bit by bit, the rounded quotient is
// registered, and done loads the output register once it is free.
// Samples at or below min, at or above max, and empty ranges skip the
// divider and go from setup straight to done.
// The block takes one item at a time; it is ready only while idle, so a
// convert item holds the input until its result reaches the output
// register, which lets the next item enter while a result waits. A stalled
// receiver holds the result, and a second finished result waits until the
// first is taken. Reset clears min and max to 0 and empties the output.
module minmax_normalize_unorm16 #(
    parameter int SAMPLE_BITS = 32,
    localparam int S_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,  // [SAMPLE_BITS-1:0] sample, rest zero
    input  logic [1:0]           i_s_tuser,  // [1:0] mode
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,  // [15:0] unorm_value
    output logic                 o_m_tuser   // [0] range_empty
);
    import mmn_pkg::*;

    localparam int SB = SAMPLE_BITS;

    t_state r_state, n_state;

    logic signed [SB-1:0] r_low, n_low;
    logic signed [SB-1:0] r_high, n_high;
    logic signed [SB-1:0] r_x, n_x;
    logic [SB-1:0]        r_den, n_den;
    logic [SB-1:0]        r_num, n_num;
    logic [QUOT_BITS-1:0] r_val, n_val;
    logic                 r_empty, n_empty;
    logic                 r_m_valid, n_m_valid;
    logic [QUOT_BITS-1:0] r_m_data, n_m_data;
    logic                 r_m_user, n_m_user;

    logic                 w_accept;
    t_mode                w_mode;
    logic signed [SB-1:0] w_sample;
    logic signed [SB:0]   w_den_ext;
    logic signed [SB:0]   w_num_ext;
    logic [SB+15:0]       w_prod;
    logic                 w_div_start;
    t_div_res             w_div;
    logic [QUOT_BITS:0]   w_rounded;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_mode     = t_mode'(i_s_tuser);
    assign w_sample   = i_s_tdata[SB-1:0];
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_den_ext = {r_high[SB-1], r_high} - {r_low[SB-1], r_low};
    assign w_num_ext = {r_x[SB-1], r_x} - {r_low[SB-1], r_low};
    // num * 65535 as (num << 16) - num
    assign w_prod    = {r_num, 16'd0} - {16'd0, r_num};
    assign w_rounded = {1'b0, w_div.quot} + {{QUOT_BITS{1'b0}}, w_div.round_up};

    mmn_div #(
        .WIDTH (SB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem_init (w_prod[SB+15:16]),
        .i_low      (w_prod[15:0]),
        .i_den      (r_den),
        .o_res      (w_div)
    );

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_x         = r_x;
        n_den       = r_den;
        n_num       = r_num;
        n_val       = r_val;
        n_empty     = r_empty;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;
        w_div_start = 1'b0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_mode)
                        MODE_RESTART: begin
                            n_low  = w_sample;
                            n_high = w_sample;
                        end
                        MODE_SCAN: begin
                            if (w_sample < r_low) begin
                                n_low = w_sample;
                            end
                            if (w_sample > r_high) begin
                                n_high = w_sample;
                            end
                        end
                        MODE_CONVERT: begin
                            n_x     = w_sample;
                            n_state = ST_SETUP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                n_den   = w_den_ext[SB-1:0];
                n_num   = w_num_ext[SB-1:0];
                n_empty = 1'b0;
                n_val   = '0;
                if (r_high <= r_low) begin
                    n_empty = 1'b1;
                    n_state = ST_DONE;
                end else if (r_x <= r_low) begin
                    n_state = ST_DONE;
                end else if (r_x >= r_high) begin
                    n_val   = UNORM_MAX;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_val   = w_rounded[QUOT_BITS] ? UNORM_MAX : w_rounded[QUOT_BITS-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // load the output register once it is free
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_val;
                    n_m_user  = r_empty;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_low     <= '0;
            r_high    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_low     <= n_low;
            r_high    <= n_high;
            r_m_valid <= n_m_valid;
        end
        r_x      <= n_x;
        r_den    <= n_den;
        r_num    <= n_num;
        r_val    <= n_val;
        r_empty  <= n_empty;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the min/max unorm16 normalizer.
module tb_top;
    import mmn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 257;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [15:0] value;
        logic        empty;
    } t_unorm_result;

    // Tracks the scanned range, predicts each conversion and checks results.
    class unorm_scoreboard;
        logic signed [SAMPLE_W-1:0] range_lo;
        logic signed [SAMPLE_W-1:0] range_hi;
        t_unorm_result              expected_q[$];
        int                         errors;
        int                         n_inputs;
        int                         n_results;
        int                         n_empty;

        function new();
            range_lo  = '0;
            range_hi  = '0;
            errors    = 0;
            n_inputs  = 0;
            n_results = 0;
            n_empty   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_mode mode, logic [SAMPLE_W-1:0] raw);
            logic signed [SAMPLE_W-1:0] x;
            longint                     span;
            longint                     offset;
            logic [63:0]                prod;
            logic [63:0]                quot;
            logic [63:0]                rem;
            t_unorm_result              res;
            x = raw;
            n_inputs++;
            case (mode)
                MODE_RESTART: begin
                    range_lo = x;
                    range_hi = x;
                end
                MODE_SCAN: begin
                    if (x < range_lo) range_lo = x;
                    if (x > range_hi) range_hi = x;
                end
                MODE_CONVERT: begin
                    res.value = '0;
                    res.empty = 1'b0;
                    if (range_hi <= range_lo) begin
                        res.empty = 1'b1;
                    end else if (x > range_lo) begin
                        span   = longint'(range_hi) - longint'(range_lo);
                        offset = longint'(x) - longint'(range_lo);
                        if (offset >= span) begin
                            res.value = UNORM_MAX;
                        end else begin
                            prod = 64'(offset) * 64'd65535;
                            quot = prod / 64'(span);
                            rem  = prod % 64'(span);
                            // round exact halves up
                            if ((rem << 1) >= 64'(span)) quot = quot + 1;
                            if (quot > 64'd65535) quot = 64'd65535;
                            res.value = quot[15:0];
                        end
                    end
                    expected_q.insert(expected_q.size(), res);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [15:0] value, logic empty);
            t_unorm_result exp_res;
            if (expected_q.size() == 0) begin
                $error("unexpected result: unorm_value %0d, range_empty %0b", value, empty);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            n_results++;
            if (exp_res.empty) n_empty++;
            if (value !== exp_res.value) begin
                $error("unorm_value: expected %0d, got %0d", exp_res.value, value);
                errors++;
            end
            if (empty !== exp_res.empty) begin
                $error("range_empty: expected %0b, got %0b", exp_res.empty, empty);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [SAMPLE_W-1:0] i_s_tdata = '0;   // [31:0] sample
    logic [1:0]          i_s_tuser = '0;   // [1:0] mode
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [15:0]         o_m_tdata;        // [15:0] unorm_value
    logic                o_m_tuser;        // [0] range_empty

    unorm_scoreboard unorm_sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    bit hold_taken     = 1'b0;
    int items_sent     = 0;
    int stall_cycles   = 0;

    minmax_normalize_unorm16 #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            unorm_sb.check_result(o_m_tdata, o_m_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_mode mode, logic [SAMPLE_W-1:0] sample);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= sample;
        do @(posedge i_clk); while (!o_s_tready);
        unorm_sb.note_input(mode, sample);
        if (mode != MODE_NOP) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (unorm_sb.pending() != 0);
    endtask

    function automatic logic [31:0] pick_span();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return $urandom_range(1, 4);
            2:       return $urandom_range(5, 300);
            3:       return $urandom_range(301, 1 << 20);
            4:       return $urandom_range((1 << 20) + 1, 1 << 30);
            default: return $urandom;
        endcase
    endfunction

    // Sample around base within span; now and then an extreme value.
    function automatic logic [SAMPLE_W-1:0] near(logic [31:0] base, logic [31:0] span);
        if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return base + $urandom_range(0, span) - (span >> 1);
    endfunction

    task automatic run_random(int target);
        int          start;
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] conv_span;
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(0, 99) < 85) begin
                base      = $urandom;
                span      = pick_span();
                conv_span = (span > 32'hC000_0000) ? span : span + (span >> 2) + 2;
                // mostly restart; sometimes extend the previous range instead
                if ($urandom_range(0, 9) != 0) send_item(MODE_RESTART, near(base, span));
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 19) == 0) send_item(MODE_NOP, $urandom);
                    send_item(MODE_SCAN, near(base, span));
                end
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 19) == 0) send_item(MODE_NOP, $urandom);
                    send_item(MODE_CONVERT, near(base, conv_span));
                end
            end else begin
                repeat ($urandom_range(1, 4)) send_item(t_mode'($urandom_range(0, 3)), $urandom);
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty range right after reset
        send_item(MODE_CONVERT, 32'h1234_5678);
        // scan without restart keeps zero in the range
        send_item(MODE_SCAN,    32'h0001_0000);
        send_item(MODE_CONVERT, 32'h0000_8000);
        send_item(MODE_CONVERT, 32'hFFFF_0000);
        send_item(MODE_CONVERT, 32'h0002_0000);
        send_item(MODE_NOP,     32'hFFFF_FFFF);
        send_item(MODE_RESTART, 32'h8000_0000);
        send_item(MODE_CONVERT, 32'h8000_0000);
        // widest possible range
        send_item(MODE_SCAN,    32'h7FFF_FFFF);
        send_item(MODE_CONVERT, 32'h8000_0000);
        send_item(MODE_CONVERT, 32'h7FFF_FFFF);
        send_item(MODE_CONVERT, 32'h0000_0000);
        send_item(MODE_CONVERT, 32'hFFFF_FFFF);
        // range of one at the top
        send_item(MODE_RESTART, 32'h7FFF_FFFF);
        send_item(MODE_SCAN,    32'h7FFF_FFFE);
        send_item(MODE_CONVERT, 32'h7FFF_FFFE);
        send_item(MODE_CONVERT, 32'h7FFF_FFFF);
        // range of three: thirds of full scale
        send_item(MODE_RESTART, 32'hFFFF_FFFE);
        send_item(MODE_SCAN,    32'h0000_0001);
        send_item(MODE_CONVERT, 32'hFFFF_FFFF);
        send_item(MODE_CONVERT, 32'h0000_0000);
        send_item(MODE_NOP,     32'h0000_0000);
        drain_results();

        // no idling, with one long receiver hold-off to back up the input
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 63;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 63;
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_random(PHASE_ITEMS);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d items; checked %0d conversions, %0d of them on an empty range",
                 unorm_sb.n_inputs, unorm_sb.n_results, unorm_sb.n_empty);
        $display("phases: free flow, sender gaps, receiver stalls, light mixed idling");
        if (unorm_sb.errors == 0 && unorm_sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
